### design/htsm_pkg.sv
package htsm_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MIN_VALID     = 3'd0;
  localparam logic [2:0] REG_MAX_VALID     = 3'd1;
  localparam logic [2:0] REG_EXTRUDE_READY = 3'd2;
  localparam logic [2:0] REG_FAN_ON        = 3'd3;
  localparam logic [2:0] REG_WD_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_TICK_PERIOD   = 3'd5;

  // register reset values
  localparam logic signed [15:0] MIN_VALID_RST     = 16'sd50;
  localparam logic signed [15:0] MAX_VALID_RST     = 16'sd2900;
  localparam logic signed [15:0] EXTRUDE_READY_RST = 16'sd1700;
  localparam logic signed [15:0] FAN_ON_RST        = 16'sd500;
  localparam logic [29:0]        WD_TIMEOUT_RST    = 30'd20000000;
  localparam logic [19:0]        TICK_PERIOD_RST   = 20'd1000;

  // heating margin 3.0 degrees and required rise 2.0 degrees, in tenths
  localparam logic signed [16:0] RISE_MARGIN = 17'sd30;
  localparam logic signed [16:0] MIN_RISE    = 17'sd20;
  localparam logic [30:0]        TIMER_MAX   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [15:0] measured_temperature;
    logic signed [15:0] requested_temperature;
    logic signed [15:0] pid_drive;
    logic               machine_on;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] safe_target;
    logic signed [15:0] safe_drive;
    logic               fan_on;
    logic               temperature_ready;
    logic               range_fault;
    logic               watchdog_fault;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] min_valid_temperature;
    logic signed [15:0] max_valid_temperature;
    logic signed [15:0] extrude_ready_temperature;
    logic signed [15:0] fan_on_temperature;
    logic [29:0]        watchdog_timeout_us;
    logic [19:0]        tick_period_us;
  } cfg_t;

endpackage

### design/heater_thermal_safety_monitor_core.sv
// heater thermal safety monitor, one servo tick per item
// input channel: in_valid / in_stall carrying in_data (measured and requested
//   temperature, pid drive, machine enable); an item is taken when in_valid is
//   high and in_stall is low
// output channel: out_valid / out_stall carrying out_data (gated target and
//   drive, fan, ready, range fault and watchdog fault flags)
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_value;
//   cfg_ready is always high, indexes beyond the register list are ignored
// flow: an accepted item passes the input register, then the result register,
//   before out_valid rises; throughput one item per cycle while the output is
//   not stalled, set by the single watchdog timer accumulate and compare between
//   the two registers
// reset: config registers return to their defaults, the heating timer,
//   baseline and fault latch clear, and both stages empty
// receiver stall: the result register holds its item; an empty input register
//   still takes one more item, after which in_stall rises until the output
//   frees up, so no item is lost or repeated
module heater_thermal_safety_monitor_core import htsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [29:0] cfg_value
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  out_item_t result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_valid_temperature     <= MIN_VALID_RST;
      cfg.max_valid_temperature     <= MAX_VALID_RST;
      cfg.extrude_ready_temperature <= EXTRUDE_READY_RST;
      cfg.fan_on_temperature        <= FAN_ON_RST;
      cfg.watchdog_timeout_us       <= WD_TIMEOUT_RST;
      cfg.tick_period_us            <= TICK_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_VALID:     cfg.min_valid_temperature     <= cfg_value[15:0];
        REG_MAX_VALID:     cfg.max_valid_temperature     <= cfg_value[15:0];
        REG_EXTRUDE_READY: cfg.extrude_ready_temperature <= cfg_value[15:0];
        REG_FAN_ON:        cfg.fan_on_temperature        <= cfg_value[15:0];
        REG_WD_TIMEOUT:    cfg.watchdog_timeout_us       <= cfg_value;
        REG_TICK_PERIOD:   cfg.tick_period_us            <= cfg_value[19:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  // tick evaluation and watchdog state
  htsm_step u_step (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (s1_item),
    .fire   (advance),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

### design/htsm_step.sv
module htsm_step import htsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      fire,
  output out_item_t result
);

  // watchdog state
  logic [30:0]        heat_timer_us;
  logic signed [15:0] baseline_temperature;
  logic               watchdog_fault_latch;

  logic [30:0]        heat_timer_us_next;
  logic signed [15:0] baseline_temperature_next;
  logic               watchdog_fault_latch_next;

  logic signed [16:0] meas_x;
  logic signed [16:0] req_x;
  logic signed [16:0] base_x;
  logic [31:0]        timer_sum;
  logic [30:0]        timer_sat;
  logic               heating;
  logic               expired;
  logic               no_rise;
  logic               trip;
  logic               rfault;

  // widened temperatures for margin compares
  assign meas_x = {item.measured_temperature[15], item.measured_temperature};
  assign req_x  = {item.requested_temperature[15], item.requested_temperature};
  assign base_x = {baseline_temperature[15], baseline_temperature};

  // heating request and timer advance
  assign heating   = item.machine_on && (req_x > meas_x + RISE_MARGIN);
  assign timer_sum = {1'b0, heat_timer_us} + {12'b0, cfg.tick_period_us};
  assign timer_sat = timer_sum[31] ? TIMER_MAX : timer_sum[30:0];
  assign expired   = timer_sat >= {1'b0, cfg.watchdog_timeout_us};
  assign no_rise   = meas_x < base_x + MIN_RISE;
  assign trip      = heating && expired && no_rise;

  assign rfault = (item.measured_temperature < cfg.min_valid_temperature) ||
                  (item.measured_temperature > cfg.max_valid_temperature);

  // next watchdog state
  always_comb begin
    heat_timer_us_next        = 31'd0;
    baseline_temperature_next = item.measured_temperature;
    watchdog_fault_latch_next = 1'b0;
    if (heating) begin
      watchdog_fault_latch_next = watchdog_fault_latch | (expired && no_rise);
      if (!expired) begin
        heat_timer_us_next        = timer_sat;
        baseline_temperature_next = baseline_temperature;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_timer_us        <= 31'd0;
      baseline_temperature <= 16'sd0;
      watchdog_fault_latch <= 1'b0;
    end else if (fire) begin
      heat_timer_us        <= heat_timer_us_next;
      baseline_temperature <= baseline_temperature_next;
      watchdog_fault_latch <= watchdog_fault_latch_next;
    end
  end

  // result fields
  always_comb begin
    result.safe_target       = item.machine_on ? item.requested_temperature : 16'sd0;
    result.safe_drive        = (!item.machine_on || rfault || trip) ? 16'sd0
                                                                    : item.pid_drive;
    result.fan_on            = item.measured_temperature > cfg.fan_on_temperature;
    result.temperature_ready = item.measured_temperature >= cfg.extrude_ready_temperature;
    result.range_fault       = rfault;
    result.watchdog_fault    = watchdog_fault_latch_next;
  end

endmodule

### design/htsm_checker.sv
module htsm_checker import htsm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // both stages are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // range fault always kills the drive
  a_range_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_fault |-> out_data.safe_drive == 16'sd0)
    else $error("drive passed on range fault");

  // a free output never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // after an accepted item, out_valid is high once it has passed the input and result registers
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted item produced no result");

endmodule

bind heater_thermal_safety_monitor_core htsm_checker u_htsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/heater_thermal_safety_monitor_core_tb.sv
module heater_thermal_safety_monitor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htsm_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 3;
  localparam int GAP_MAX       = 11;
  localparam int LONG_HOLD     = 64;
  localparam int DRAIN_CYCLES  = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 150;

  // predicts gated outputs and watchdog state per tick, checks results in order
  class safety_scoreboard;
    cfg_t      regs;
    longint    heat_timer;
    int        baseline;
    bit        wd_latch;
    out_item_t gated_results_q[$];
    int        errors;
    int        results_seen;

    function new();
      regs.min_valid_temperature     = MIN_VALID_RST;
      regs.max_valid_temperature     = MAX_VALID_RST;
      regs.extrude_ready_temperature = EXTRUDE_READY_RST;
      regs.fan_on_temperature        = FAN_ON_RST;
      regs.watchdog_timeout_us       = WD_TIMEOUT_RST;
      regs.tick_period_us            = TICK_PERIOD_RST;
      heat_timer   = 0;
      baseline     = 0;
      wd_latch     = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return gated_results_q.size();
    endfunction

    // register write; unmapped indexes are dropped
    function void set_register(logic [2:0] idx, logic [29:0] val);
      case (idx)
        REG_MIN_VALID:     regs.min_valid_temperature = val[15:0];
        REG_MAX_VALID:     regs.max_valid_temperature = val[15:0];
        REG_EXTRUDE_READY: regs.extrude_ready_temperature = val[15:0];
        REG_FAN_ON:        regs.fan_on_temperature = val[15:0];
        REG_WD_TIMEOUT:    regs.watchdog_timeout_us = val;
        REG_TICK_PERIOD:   regs.tick_period_us = val[19:0];
        default: ;
      endcase
    endfunction

    // one servo tick: gating, range check, heating watchdog
    function void note_tick(in_item_t it);
      out_item_t res;
      int        meas;
      int        goal;
      int        drive;
      bit        en;
      bit        out_of_range;
      longint    sum;
      meas  = it.measured_temperature;
      en    = it.machine_on;
      goal  = en ? it.requested_temperature : 0;
      drive = en ? it.pid_drive : 0;
      out_of_range = (meas < regs.min_valid_temperature) ||
                     (meas > regs.max_valid_temperature);
      if (out_of_range) drive = 0;
      if (en && goal > meas + RISE_MARGIN) begin
        sum = heat_timer + regs.tick_period_us;
        if (sum > TIMER_MAX) sum = TIMER_MAX;
        heat_timer = sum;
        if (heat_timer >= regs.watchdog_timeout_us) begin
          if (meas < baseline + MIN_RISE) begin
            wd_latch = 1'b1;
            drive    = 0;
          end
          heat_timer = 0;
          baseline   = meas;
        end
      end else begin
        heat_timer = 0;
        baseline   = meas;
        wd_latch   = 1'b0;
      end
      res.safe_target       = goal[15:0];
      res.safe_drive        = drive[15:0];
      res.fan_on            = meas > regs.fan_on_temperature;
      res.temperature_ready = meas >= regs.extrude_ready_temperature;
      res.range_fault       = out_of_range;
      res.watchdog_fault    = wd_latch;
      gated_results_q.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_output(out_item_t got);
      out_item_t want;
      results_seen++;
      if (gated_results_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = gated_results_q.pop_front();
      if (got.safe_target !== want.safe_target)
        report($sformatf("safe_target %0d, want %0d", got.safe_target, want.safe_target));
      if (got.safe_drive !== want.safe_drive)
        report($sformatf("safe_drive %0d, want %0d", got.safe_drive, want.safe_drive));
      if (got.fan_on !== want.fan_on)
        report($sformatf("fan_on %b, want %b", got.fan_on, want.fan_on));
      if (got.temperature_ready !== want.temperature_ready)
        report($sformatf("temperature_ready %b, want %b",
                         got.temperature_ready, want.temperature_ready));
      if (got.range_fault !== want.range_fault)
        report($sformatf("range_fault %b, want %b", got.range_fault, want.range_fault));
      if (got.watchdog_fault !== want.watchdog_fault)
        report($sformatf("watchdog_fault %b, want %b",
                         got.watchdog_fault, want.watchdog_fault));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [29:0] cfg_value = '0;

  safety_scoreboard sb;
  bit  gaps_on = 1'b1;
  int  ticks_sent = 0;
  int  quiet_cycles = 0;
  int  cur_temp = 200;
  int  run_left = 0;
  int  rise_rate = 2;

  heater_thermal_safety_monitor_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // observe accepted writes, items and results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_value);
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (out_valid && !out_stall) sb.check_output(out_data);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : timeout_guard
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall per item, two long hold-offs to back up the block
  initial begin : result_side
    int hold;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      if (taken == 100 || taken == 700) hold = LONG_HOLD;
      else hold = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send_tick(in_item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic send_fields(int meas, int req, int drv, bit en);
    in_item_t it;
    it.measured_temperature  = 16'(meas);
    it.requested_temperature = 16'(req);
    it.pid_drive             = 16'(drv);
    it.machine_on            = en;
    send_tick(it);
  endtask

  // let every result come back and the pipeline settle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.results_seen < ticks_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [29:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all six registers, junk in unused upper bits, sometimes an unmapped index
  task automatic apply_cfg(cfg_t c);
    write_reg(REG_MIN_VALID, {14'($urandom), c.min_valid_temperature});
    write_reg(REG_MAX_VALID, {14'($urandom), c.max_valid_temperature});
    write_reg(REG_EXTRUDE_READY, {14'($urandom), c.extrude_ready_temperature});
    write_reg(REG_FAN_ON, {14'($urandom), c.fan_on_temperature});
    write_reg(REG_WD_TIMEOUT, c.watchdog_timeout_us);
    write_reg(REG_TICK_PERIOD, {10'($urandom), c.tick_period_us});
    if ($urandom_range(0, 1))
      write_reg(REG_TICK_PERIOD + 3'd1 + 3'($urandom_range(0, 1)), 30'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t   c;
    longint span;
    case ($urandom_range(0, 3))
      0: begin
        c.min_valid_temperature = 16'(int'($urandom_range(0, 2500)) - 2000);
        c.max_valid_temperature = 16'($urandom_range(1500, 20000));
      end
      1: begin
        c.min_valid_temperature = 16'($urandom_range(1000, 20000));
        c.max_valid_temperature = c.min_valid_temperature - 16'($urandom_range(1, 3000));
      end
      2: begin
        c.min_valid_temperature = 16'($urandom);
        c.max_valid_temperature = 16'($urandom);
      end
      default: begin
        c.min_valid_temperature = 16'sh8000;
        c.max_valid_temperature = 16'sh7FFF;
      end
    endcase
    c.extrude_ready_temperature = 16'(int'($urandom_range(0, 22000)) - 2000);
    c.fan_on_temperature        = 16'(int'($urandom_range(0, 22000)) - 2000);
    case ($urandom_range(0, 5))
      0:       c.tick_period_us = 20'd0;
      1:       c.tick_period_us = 20'd1;
      2:       c.tick_period_us = 20'hFFFFF;
      default: c.tick_period_us = 20'($urandom_range(1, 1000000));
    endcase
    // timeout a small multiple of the tick so runs reach the rise check
    span = longint'(c.tick_period_us) * $urandom_range(0, 15);
    if ($urandom_range(0, 5) == 0) c.watchdog_timeout_us = 30'($urandom);
    else if (span > 30'h3FFFFFFF) c.watchdog_timeout_us = 30'h3FFFFFFF;
    else c.watchdog_timeout_us = 30'(span);
    return c;
  endfunction

  // mostly heating runs with a steady rise, some idle ticks, some pure noise
  function automatic in_item_t next_tick();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.pid_drive = 16'($urandom);
    if (pick < 10) begin
      it.measured_temperature  = 16'($urandom);
      it.requested_temperature = 16'($urandom);
      it.machine_on            = 1'($urandom);
    end else if (run_left > 0) begin
      it.measured_temperature  = 16'(cur_temp);
      it.requested_temperature = 16'(cur_temp + int'($urandom_range(31, 3000)));
      it.machine_on            = (pick >= 14);
      cur_temp = cur_temp + int'($urandom_range(0, rise_rate));
      if (cur_temp > 20000) cur_temp = 20000;
      run_left--;
    end else begin
      if (pick < 30) begin
        run_left  = $urandom_range(1, 40);
        rise_rate = $urandom_range(0, 6);
        if (pick < 18) cur_temp = int'($urandom_range(0, 22000)) - 2000;
      end
      it.measured_temperature  = 16'(cur_temp);
      it.requested_temperature = 16'(cur_temp + int'($urandom_range(0, 230)) - 200);
      it.machine_on            = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  initial begin : stimulus
    cfg_t c;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds: field extremes, disable, fan, ready and range edges
    send_fields(200, 2000, 32767, 1'b1);
    send_fields(-32768, 32767, -32768, 1'b1);
    send_fields(32767, -32768, 12345, 1'b0);
    send_fields(500, 510, 100, 1'b1);
    send_fields(501, 400, -100, 1'b1);
    send_fields(1699, 0, 0, 1'b1);
    send_fields(1700, 1600, 7, 1'b1);
    send_fields(49, 49, 300, 1'b1);
    send_fields(2900, 2000, 300, 1'b1);
    send_fields(2901, 3000, 300, 1'b1);
    send_fields(1000, 1030, 555, 1'b1);
    send_fields(1000, 1031, 555, 1'b1);

    // zero timeout and zero tick: every heating tick runs the rise check
    drain();
    c = '{MIN_VALID_RST, MAX_VALID_RST, EXTRUDE_READY_RST, FAN_ON_RST, 30'd0, 20'd0};
    apply_cfg(c);
    send_fields(1000, 2000, 900, 1'b1);
    send_fields(1025, 2000, 900, 1'b1);
    send_fields(1030, 1000, 900, 1'b1);
    send_fields(100, 2000, 900, 1'b0);

    // inverted range, timer runs up part way
    drain();
    c = '{16'sd3000, 16'sd100, EXTRUDE_READY_RST, FAN_ON_RST, 30'd5000, 20'd1000};
    apply_cfg(c);
    send_fields(500, 400, 1, 1'b1);
    repeat (3) send_fields(500, 1000, 2, 1'b1);

    // timeout dropped below the running timer: next heating tick checks
    drain();
    c.watchdog_timeout_us = 30'd2000;
    apply_cfg(c);
    send_fields(505, 1000, 3, 1'b1);

    // random phases, the first two at the register extremes, the third at fixed settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: c = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 30'h3FFFFFFF, 20'hFFFFF};
        1: c = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 30'd0, 20'd0};
        2: c = '{-16'sd2000, 16'sd20000, 16'sd20000, -16'sd2000, 30'd1000000000,
                 20'd1000000};
        default: c = random_cfg();
      endcase
      apply_cfg(c);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        send_tick(next_tick());
      end
    end

    gaps_on = 1'b1;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
